@@ rtl/multi_timer_table_core_assert.svh @@
// Assertion macros for the timer table core.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef MULTI_TIMER_TABLE_CORE_ASSERT_SVH
`define MULTI_TIMER_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define MTT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timer table check failed");

// next-cycle implication
`define MTT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timer table check failed");

`endif

@@ rtl/mtt_pkg.sv @@
// Shared constants and types for the timer table core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mtt_pkg;

	localparam int NUM_TIMERS = 8;
	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CNT_W = $clog2(NUM_TIMERS + 1);

	typedef enum logic [1:0] {
		REQ_DECLARE = 2'd0,
		REQ_CANCEL  = 2'd1,
		REQ_ADVANCE = 2'd2,
		REQ_NONE    = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DONE
	} walk_state_t;

endpackage

`default_nettype wire

@@ rtl/multi_timer_table_core.sv @@
// Timer table core: NUM_TIMERS one-shot timers sharing one time base.
// Uses mtt_pkg and the assertion macros in multi_timer_table_core_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

// channel   handshake            word
// -------   ------------------   -----------------------------------------------
// in        in_valid / in_stall  req_type, interval_us, slot, elapsed_us
// out       out_valid/out_stall  accepted, slot_granted, expired_mask,
//                                next_valid, next_slot, next_remaining
//
// An item is handled by a walk over the remaining-time RAM: one read per entry
// through its registered read port, then the word is handed to the output
// register, which waits while a held output word is stalled.
// The slot-in-use bits are flip-flops cleared by arst_n; the RAM is not reset
// and an entry's read data is only used while its slot is in use.
// A stalled output word holds; the next input word is taken while it waits.

module multi_timer_table_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic [31:0] interval_us,
	input  wire logic [2:0]  slot,
	input  wire logic [31:0] elapsed_us,
	// output channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             accepted,
	output logic [2:0]       slot_granted,
	output logic [7:0]       expired_mask,
	output logic             next_valid,
	output logic [2:0]       next_slot,
	output logic [31:0]      next_remaining
);

	localparam int N = mtt_pkg::NUM_TIMERS;
	localparam int IW = mtt_pkg::IDX_W;
	localparam int CW = mtt_pkg::CNT_W;

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	mtt_pkg::walk_state_t state_q, state_nx;
	logic [CW-1:0] cnt_q;        // walk read pointer, runs 0..N
	logic          issue;        // a RAM read goes out this cycle
	logic          in_take;
	logic          out_load;

	// ---------------------------------------------------------------
	// Latched request
	// ---------------------------------------------------------------
	mtt_pkg::req_kind_t op_q;
	logic [31:0]   interval_q;
	logic [31:0]   elapsed_q;
	logic [IW-1:0] slot_idx_q;
	logic          slot_ok_q;    // cancel target exists in this table

	// ---------------------------------------------------------------
	// Table state
	// ---------------------------------------------------------------
	logic [N-1:0]  in_use_q;
	logic [31:0]   mem_q [N];
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic [31:0]   wr_data;
	logic [31:0]   rd_data_s1;
	logic [IW-1:0] idx_s1;
	logic          valid_s1;

	// ---------------------------------------------------------------
	// Per-item results being built during the walk
	// ---------------------------------------------------------------
	logic          acc_q;
	logic          granted_q;    // declare already placed
	logic [IW-1:0] grant_idx_q;
	logic [7:0]    mask_q;
	logic          found_q;
	logic [IW-1:0] best_idx_q;
	logic [31:0]   best_rem_q;

	// walk stage decode
	logic          use_s1;
	logic          set_bit, clr_bit;
	logic          cand_v;
	logic [31:0]   cand;
	logic          take_best;

	// output register
	logic          out_valid_q;
	logic          acc_out_q;
	logic [2:0]    grant_out_q;
	logic [7:0]    mask_out_q;
	logic          nv_out_q;
	logic [2:0]    ns_out_q;
	logic [31:0]   nr_out_q;

	// ---------------------------------------------------------------
	// FSM: next state
	// ---------------------------------------------------------------
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			mtt_pkg::ST_IDLE: begin
				if (in_take) state_nx = mtt_pkg::ST_WALK;
			end
			mtt_pkg::ST_WALK: begin
				if (cnt_q == CW'(N)) state_nx = mtt_pkg::ST_DONE;
			end
			mtt_pkg::ST_DONE: begin
				if (out_load) state_nx = mtt_pkg::ST_IDLE;
			end
			default: state_nx = mtt_pkg::ST_IDLE;
		endcase
	end

	// FSM: outputs
	always_comb begin
		in_stall = (state_q != mtt_pkg::ST_IDLE);
		issue    = (state_q == mtt_pkg::ST_WALK) && (cnt_q < CW'(N));
		out_load = (state_q == mtt_pkg::ST_DONE) && (!out_valid_q || !out_stall);
	end

	assign in_take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= mtt_pkg::ST_IDLE;
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_nx;
			valid_s1 <= issue;
			if (in_take)
				cnt_q <= '0;
			else if (issue)
				cnt_q <= cnt_q + CW'(1);
		end
	end

	// request latch
	always_ff @(posedge clk) begin
		if (in_take) begin
			op_q       <= mtt_pkg::req_kind_t'(req_type);
			interval_q <= interval_us;
			elapsed_q  <= elapsed_us;
			slot_idx_q <= IW'(slot);
			slot_ok_q  <= (32'(slot) < N);
		end
	end

	// ---------------------------------------------------------------
	// Remaining-time RAM: one write, one registered read per cycle.
	// Each entry is read once per walk and written back only from its own
	// walk slot, so a read never races a pending write to the same entry.
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (issue)
			rd_data_s1 <= mem_q[cnt_q[IW-1:0]];
		idx_s1 <= cnt_q[IW-1:0];
	end

	// ---------------------------------------------------------------
	// Walk stage: apply the request to one entry and feed the minimum
	// ---------------------------------------------------------------
	assign use_s1 = in_use_q[idx_s1];

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		wr_data = rd_data_s1;
		set_bit = 1'b0;
		clr_bit = 1'b0;
		cand_v  = 1'b0;
		cand    = rd_data_s1;
		if (valid_s1) begin
			unique case (op_q)
				mtt_pkg::REQ_DECLARE: begin
					if (!use_s1 && !granted_q && (interval_q != 32'd0)) begin
						// lowest free slot takes the new timer
						wr_en   = 1'b1;
						wr_data = interval_q;
						set_bit = 1'b1;
						cand_v  = 1'b1;
						cand    = interval_q;
					end else if (use_s1) begin
						cand_v = 1'b1;
					end
				end
				mtt_pkg::REQ_CANCEL: begin
					if (use_s1 && slot_ok_q && (idx_s1 == slot_idx_q))
						clr_bit = 1'b1;
					else if (use_s1)
						cand_v = 1'b1;
				end
				mtt_pkg::REQ_ADVANCE: begin
					if (use_s1) begin
						if (elapsed_q < rd_data_s1) begin
							wr_en   = 1'b1;
							wr_data = rd_data_s1 - elapsed_q;
							cand_v  = 1'b1;
							cand    = rd_data_s1 - elapsed_q;
						end else begin
							clr_bit = 1'b1;
						end
					end
				end
				mtt_pkg::REQ_NONE: begin
					cand_v = use_s1;
				end
				default: cand_v = 1'b0;
			endcase
		end
	end

	// strict less-than keeps the lowest index on a tie
	assign take_best = cand_v && (!found_q || (cand < best_rem_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q  <= '0;
			found_q   <= 1'b0;
			acc_q     <= 1'b0;
			granted_q <= 1'b0;
			mask_q    <= '0;
		end else if (in_take) begin
			found_q   <= 1'b0;
			acc_q     <= 1'b0;
			granted_q <= 1'b0;
			mask_q    <= '0;
		end else begin
			if (set_bit) begin
				in_use_q[idx_s1] <= 1'b1;
				acc_q            <= 1'b1;
				granted_q        <= 1'b1;
			end
			if (clr_bit) begin
				in_use_q[idx_s1] <= 1'b0;
				if (op_q == mtt_pkg::REQ_CANCEL)
					acc_q <= 1'b1;
				else
					mask_q <= mask_q | (8'd1 << idx_s1);  // slots past 7 fall off
			end
			if (take_best)
				found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (set_bit)
			grant_idx_q <= idx_s1;
		if (take_best) begin
			best_idx_q <= idx_s1;
			best_rem_q <= cand;
		end
	end

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			acc_out_q   <= acc_q;
			grant_out_q <= granted_q ? 3'(grant_idx_q) : 3'd0;
			mask_out_q  <= mask_q;
			nv_out_q    <= found_q;
			ns_out_q    <= found_q ? 3'(best_idx_q) : 3'd0;
			nr_out_q    <= found_q ? best_rem_q : 32'd0;
		end
	end

	assign out_valid      = out_valid_q;
	assign accepted       = acc_out_q;
	assign slot_granted   = grant_out_q;
	assign expired_mask   = mask_out_q;
	assign next_valid     = nv_out_q;
	assign next_slot      = ns_out_q;
	assign next_remaining = nr_out_q;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
`include "multi_timer_table_core_assert.svh"

	`MTT_ASSERT_NEXT(a_take_starts_walk, in_take,
		(state_q == mtt_pkg::ST_WALK) && (cnt_q == '0) && !found_q)
	`MTT_ASSERT_NOW(a_best_nonzero, found_q && (state_q != mtt_pkg::ST_IDLE),
		best_rem_q != 32'd0)
	`MTT_ASSERT_NOW(a_expire_not_accept, out_valid_q && (mask_out_q != 8'd0),
		!acc_out_q && (grant_out_q == 3'd0))

endmodule

`default_nettype wire
